FILE: rtl/spd_pkg.sv
package spd_pkg;

   // header layout
   localparam int unsigned HDR_BYTES   = 8;
   localparam int unsigned HDR_IDX_W   = $clog2(HDR_BYTES);
   localparam logic [HDR_IDX_W-1:0] HDR_FLAGS   = HDR_IDX_W'(0);
   localparam logic [HDR_IDX_W-1:0] HDR_SESS_HI = HDR_IDX_W'(2);
   localparam logic [HDR_IDX_W-1:0] HDR_SESS_LO = HDR_IDX_W'(3);
   localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI  = HDR_IDX_W'(6);
   localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO  = HDR_IDX_W'(7);

   // flag bit positions in header byte 0
   localparam int unsigned FLAG_PUSH  = 0;
   localparam int unsigned FLAG_ABORT = 1;
   localparam int unsigned FLAG_CLOSE = 2;
   localparam int unsigned FLAG_OPEN  = 3;

   // stream widths
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned RSP_USER_W = 5;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_ABORT = 2'd1,
      KIND_CLOSE = 2'd2,
      KIND_OPEN  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        byte_valid;
      logic        push_bit;
      kind_type    kind;
      logic [15:0] session_id;
      logic [15:0] frame_length;
      logic        first_of_frame;
      logic        last_of_frame;
   } rsp_type;

   // abort beats close, close beats open
   function automatic kind_type kind_of(input logic [7:0] flags);
      kind_type k;
      k = KIND_NONE;
      if (flags[FLAG_ABORT]) begin
         k = KIND_ABORT;
      end else if (flags[FLAG_CLOSE]) begin
         k = KIND_CLOSE;
      end else if (flags[FLAG_OPEN]) begin
         k = KIND_OPEN;
      end
      return k;
   endfunction

endpackage

FILE: rtl/spd_core.sv
module spd_core import spd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,        // consume in_byte this cycle
   input  logic [7:0] in_byte,
   output logic       hit,         // in_byte produces a result word
   output rsp_type    rsp
);

   logic [HDR_IDX_W-1:0] hdr_idx_ff, hdr_idx_in;
   logic                 in_payload_ff, in_payload_in;
   logic [7:0]           flags_ff, flags_in;
   logic [15:0]          session_ff, session_in;
   logic [15:0]          length_ff, length_in;
   logic [15:0]          left_ff, left_in;

   // header capture, payload countdown and result forming
   always_comb begin
      hdr_idx_in    = hdr_idx_ff;
      in_payload_in = in_payload_ff;
      flags_in      = flags_ff;
      session_in    = session_ff;
      length_in     = length_ff;
      left_in       = left_ff;
      hit           = 1'b0;

      if (in_payload_ff) begin
         hit     = 1'b1;
         left_in = left_ff - 16'd1;
         if (left_ff == 16'd1) begin
            in_payload_in = 1'b0;
            hdr_idx_in    = HDR_FLAGS;
         end
      end else begin
         case (hdr_idx_ff)
            HDR_FLAGS:   flags_in   = in_byte;
            HDR_SESS_HI: session_in = {in_byte, session_ff[7:0]};
            HDR_SESS_LO: session_in = {session_ff[15:8], in_byte};
            HDR_LEN_HI:  length_in  = {in_byte, length_ff[7:0]};
            HDR_LEN_LO:  length_in  = {length_ff[15:8], in_byte};
            default:     ;
         endcase
         if (hdr_idx_ff == HDR_LEN_LO) begin
            hdr_idx_in = HDR_FLAGS;
            if (length_in == 16'd0) begin
               hit = 1'b1;     // empty frame marker
            end else begin
               left_in       = length_in;
               in_payload_in = 1'b1;
            end
         end else begin
            hdr_idx_in = hdr_idx_ff + HDR_IDX_W'(1);
         end
      end

      rsp.data_byte      = in_payload_ff ? in_byte : 8'd0;
      rsp.byte_valid     = in_payload_ff;
      rsp.push_bit       = flags_in[FLAG_PUSH];
      rsp.kind           = kind_of(flags_in);
      rsp.session_id     = session_in;
      rsp.frame_length   = length_in;
      rsp.first_of_frame = in_payload_ff ? (left_ff == length_ff) : 1'b1;
      rsp.last_of_frame  = in_payload_ff ? (left_ff[15:1] == 15'd0) : 1'b1;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_idx_ff    <= HDR_FLAGS;
         in_payload_ff <= 1'b0;
         flags_ff      <= 8'd0;
         session_ff    <= 16'd0;
         length_ff     <= 16'd0;
         left_ff       <= 16'd0;
      end else if (step) begin
         hdr_idx_ff    <= hdr_idx_in;
         in_payload_ff <= in_payload_in;
         flags_ff      <= flags_in;
         session_ff    <= session_in;
         length_ff     <= length_in;
         left_ff       <= left_in;
      end
   end

endmodule

FILE: rtl/session_packet_deframer_unit.sv
// Channel | Dir | Handshake          | Payload
// req     | in  | req_tvalid/tready  | tdata: in_byte
// rsp     | out | rsp_tvalid/tready  | tdata, tuser, tlast: one result per word
//
// One input word per clock sustained while no result is blocked. A word is
// parsed from the input register once it can advance, and its result is
// then registered in the output register, which offers it downstream.
// Payload words give one result each; of the header words only the last gives
// one, and only for an empty frame.
// Synchronous active-high reset clears the parser and the valids of both register
// stages. A stalled output holds its word; the input register keeps taking
// words that produce no result, and stalls only when a result is blocked.
module session_packet_deframer_unit import spd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] in_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] data_byte, [23:8] session_id, [39:24] frame_length
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] byte_valid, [1] push_bit, [3:2] kind, [4] first_of_frame
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast    // last_of_frame
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   rsp_type    out_word_ff;
   logic       core_hit;
   rsp_type    core_rsp;
   logic       out_free;
   logic       advance;

   // stage control
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!core_hit || out_free);
   assign req_tready = !in_valid_ff || advance;

   spd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .hit     (core_hit),
      .rsp     (core_rsp)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && core_hit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && core_hit) begin
         out_word_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_word_ff.frame_length, out_word_ff.session_id,
                        out_word_ff.data_byte};
   assign rsp_tuser  = {out_word_ff.first_of_frame, out_word_ff.kind,
                        out_word_ff.push_bit, out_word_ff.byte_valid};
   assign rsp_tlast  = out_word_ff.last_of_frame;

endmodule

FILE: rtl/spd_checker.sv
module spd_checker import spd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast
);

   // a blocked result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // no result straight out of reset
   a_rst_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid after reset");

   // empty-frame marker is both first and last and carries no byte
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         rsp_tlast && rsp_tuser[4] && rsp_tdata[7:0] == 8'd0
         && rsp_tdata[39:24] == 16'd0)
      else $error("bad empty-frame marker");

   // a one-byte frame closes on its first word
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && rsp_tuser[4] && rsp_tdata[39:24] == 16'd1
         |-> rsp_tlast)
      else $error("one-byte frame not marked last");

   // a free output never holds off the input
   a_in_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("input stalled with the output free");

endmodule

bind session_packet_deframer_unit spd_checker u_spd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
